>>> design/dldt_pkg.sv
package dldt_pkg;

  // field widths
  localparam int DATA_W    = 24;
  localparam int LIM_W     = 23;
  localparam int RATE_W    = 16;
  localparam int CH_W      = 3;
  localparam int CNT_W     = 4;
  localparam int SUM_W     = 27;
  localparam int MASK_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_VAL_W = 23;

  // opcodes
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ETA    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEAK   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAULT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHARGE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD   = 3'd4;

  // register reset values
  localparam logic [RATE_W-1:0] ETA_RST    = 16'd655;
  localparam logic [RATE_W-1:0] LEAK_RST   = 16'd66;
  localparam logic [LIM_W-1:0]  FAULT_RST  = 23'd25600;
  localparam logic [LIM_W-1:0]  CHARGE_RST = 23'd1280;
  localparam logic [LIM_W-1:0]  HOLD_RST   = 23'd512;

  typedef enum logic [1:0] {
    PH_HOLD   = 2'd0,
    PH_CHARGE = 2'd1,
    PH_RELAX  = 2'd2,
    PH_FAULT  = 2'd3
  } phase_e;

  typedef struct packed {
    logic [1:0]               opcode;
    logic [CH_W-1:0]          channel;
    logic signed [DATA_W-1:0] sample_value;
    logic                     last_of_batch;
  } in_req_t;

  typedef struct packed {
    logic [CH_W-1:0]          channel_out;
    phase_e                   phase_code;
    logic [LIM_W-1:0]         effective_level;
    logic signed [DATA_W-1:0] baseline_out;
    logic signed [DATA_W-1:0] accum_out;
    logic                     isolation_ok;
    logic [MASK_W-1:0]        fault_mask;
    logic signed [DATA_W-1:0] mean_accum;
  } out_rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_VAL_W-1:0] value;
  } cfg_req_t;

endpackage

>>> design/dldt_if.sv
interface dldt_in_if;
  import dldt_pkg::*;
  logic    valid;
  logic    ready;
  in_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dldt_out_if;
  import dldt_pkg::*;
  logic     valid;
  logic     ready;
  out_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dldt_cfg_if;
  import dldt_pkg::*;
  logic     valid;
  logic     ready;
  cfg_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/dark_level_drift_tracker_top.sv
// Dark level drift tracker. Each request addresses one channel: a load sets its baseline
// and restarts its leaky integrator, an update feeds one dark sample through the
// integrator and reclassifies the channel (hold, charge, relax, fault), and a read
// leaves the state alone. Every request returns one response with the channel view and
// the status over all active channels. Requests are taken one at a time; in_i.ready is
// high only while the block is idle, and a finished response waits in an output
// register so the next request can be taken before it is drained. One shared multiplier
// runs the gain and leak steps in turn, the active channels are summed one per cycle,
// and the mean comes from a serial divider that produces one of 27 quotient bits per
// cycle while the sequencer waits in its divide step. With no active channel the
// division is skipped. A stalled response receiver holds the sequencer in its last step
// until the output register is free.
module dark_level_drift_tracker_top #(
  parameter int CHANNELS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dldt_in_if.sink     in_i,
  dldt_out_if.source  out_o,
  dldt_cfg_if.sink    cfg_i
);
  import dldt_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MAX_EFF = 8388607;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL1,
    ST_ACC1,
    ST_MUL2,
    ST_ACC2,
    ST_VIEW,
    ST_SCAN,
    ST_DIV,
    ST_FINISH
  } state_e;

  state_e state_q;

  // configuration registers
  logic [RATE_W-1:0] eta_q;
  logic [RATE_W-1:0] leak_q;
  logic [LIM_W-1:0]  fault_q;
  logic [LIM_W-1:0]  charge_q;
  logic [LIM_W-1:0]  hold_q;

  // per-channel stores
  logic signed [DATA_W-1:0] base_mem_q  [CHANNELS];
  logic signed [DATA_W-1:0] accum_mem_q [CHANNELS];
  logic signed [DATA_W-1:0] prev_mem_q  [CHANNELS];
  phase_e                   phase_mem_q [CHANNELS];

  // sequencer registers
  in_req_t                  item_q;
  logic [CNT_W-1:0]         idx_q;
  logic [CNT_W-1:0]         active_q;
  logic signed [DATA_W-1:0] q1_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic                     iso_q;
  logic [MASK_W-1:0]        mask_q;
  phase_e                   view_phase_q;
  logic [LIM_W-1:0]         view_eff_q;
  logic signed [DATA_W-1:0] view_base_q;
  logic signed [DATA_W-1:0] view_accum_q;
  logic signed [DATA_W-1:0] mean_q;
  logic                     out_valid_q;
  out_rsp_t                 out_q;

  // datapath signals
  logic [IDX_W-1:0]         rd_idx;
  logic signed [DATA_W-1:0] rd_base;
  logic signed [DATA_W-1:0] rd_accum;
  logic signed [DATA_W-1:0] rd_prev;
  phase_e                   rd_phase;
  logic [CNT_W-1:0]         ch_ext;
  logic                     in_range;
  logic [CNT_W-1:0]         lim;
  logic signed [DATA_W:0]   resid;
  logic [DATA_W+1:0]        abs_resid;
  logic [DATA_W:0]          abs_acc;
  logic signed [DATA_W:0]   mac_a;
  logic [RATE_W:0]          mac_b;
  logic signed [DATA_W-1:0] mac_addend;
  logic signed [DATA_W-1:0] mac_res;
  logic                     mac_en;
  phase_e                   phase_new;
  logic signed [DATA_W:0]   eff_sum;
  logic [LIM_W-1:0]         eff_lvl;
  logic                     div_start;
  logic                     div_done;
  logic signed [DATA_W-1:0] div_quot;

  // single store read port, addressed by the sequencer index
  assign rd_idx   = idx_q[IDX_W-1:0];
  assign rd_base  = base_mem_q[rd_idx];
  assign rd_accum = accum_mem_q[rd_idx];
  assign rd_prev  = prev_mem_q[rd_idx];
  assign rd_phase = phase_mem_q[rd_idx];

  // channel range and batch count limit
  assign ch_ext   = {1'b0, item_q.channel};
  assign in_range = ch_ext < CNT_W'(CHANNELS);
  assign lim      = (ch_ext + CNT_W'(1) > CNT_W'(CHANNELS)) ? CNT_W'(CHANNELS)
                                                             : ch_ext + CNT_W'(1);

  // residual against the baseline
  assign resid     = (DATA_W+1)'(item_q.sample_value) - (DATA_W+1)'(rd_base);
  assign abs_resid = resid[DATA_W] ? (DATA_W+2)'(0) - (DATA_W+2)'(resid) : (DATA_W+2)'(resid);
  assign abs_acc   = mac_res[DATA_W-1] ? (DATA_W+1)'(0) - (DATA_W+1)'(mac_res)
                                       : (DATA_W+1)'(mac_res);

  // shared multiply unit operands: gain step, then leak step
  always_comb begin
    mac_en     = (state_q == ST_MUL1) || (state_q == ST_MUL2);
    mac_a      = (state_q == ST_MUL1) ? resid : (DATA_W+1)'(q1_q);
    mac_b      = (state_q == ST_MUL1) ? {1'b0, eta_q}
                                      : (RATE_W+1)'(1 << RATE_W) - {1'b0, leak_q};
    mac_addend = (state_q == ST_ACC1) ? rd_accum : '0;
  end

  dldt_mac u_mac (
    .clk_i    (clk_i),
    .en_i     (mac_en),
    .a_i      (mac_a),
    .b_i      (mac_b),
    .addend_i (mac_addend),
    .res_o    (mac_res)
  );

  // phase classification, first match wins
  always_comb begin
    if (abs_acc >= (DATA_W+1)'(fault_q) || abs_resid >= (DATA_W+2)'(fault_q)) begin
      phase_new = PH_FAULT;
    end else if (resid > $signed((DATA_W+1)'(charge_q)) &&
                 item_q.sample_value > rd_prev) begin
      phase_new = PH_CHARGE;
    end else if (abs_acc > (DATA_W+1)'(hold_q)) begin
      phase_new = PH_RELAX;
    end else begin
      phase_new = PH_HOLD;
    end
  end

  // effective level clamped to the unsigned range
  always_comb begin
    eff_sum = (DATA_W+1)'(rd_base) + (DATA_W+1)'(rd_accum);
    if (eff_sum[DATA_W]) begin
      eff_lvl = '0;
    end else if (eff_sum[DATA_W-1]) begin
      eff_lvl = LIM_W'(MAX_EFF);
    end else begin
      eff_lvl = eff_sum[LIM_W-1:0];
    end
  end

  // configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eta_q    <= ETA_RST;
      leak_q   <= LEAK_RST;
      fault_q  <= FAULT_RST;
      charge_q <= CHARGE_RST;
      hold_q   <= HOLD_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        REG_ETA:    eta_q    <= cfg_i.data.value[RATE_W-1:0];
        REG_LEAK:   leak_q   <= cfg_i.data.value[RATE_W-1:0];
        REG_FAULT:  fault_q  <= cfg_i.data.value[LIM_W-1:0];
        REG_CHARGE: charge_q <= cfg_i.data.value[LIM_W-1:0];
        REG_HOLD:   hold_q   <= cfg_i.data.value[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // channel stores: load writes in LOAD, update writes in ACC2
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        base_mem_q[i]  <= '0;
        accum_mem_q[i] <= '0;
        prev_mem_q[i]  <= '0;
        phase_mem_q[i] <= PH_HOLD;
      end
    end else if (in_range) begin
      if (state_q == ST_LOAD) begin
        base_mem_q[rd_idx]  <= item_q.sample_value;
        accum_mem_q[rd_idx] <= '0;
        prev_mem_q[rd_idx]  <= item_q.sample_value;
        phase_mem_q[rd_idx] <= PH_HOLD;
      end else if (state_q == ST_ACC2) begin
        accum_mem_q[rd_idx] <= mac_res;
        prev_mem_q[rd_idx]  <= item_q.sample_value;
        phase_mem_q[rd_idx] <= phase_new;
      end
    end
  end

  // mean over active channels
  assign div_start = (state_q == ST_SCAN) && !(idx_q < active_q) && (active_q != '0);

  dldt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (active_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // response drained, unless the next one is loaded in this cycle
      if (out_valid_q && out_o.ready && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            item_q <= in_i.data;
            idx_q  <= {1'b0, in_i.data.channel};
            if (in_i.data.opcode == OP_LOAD) begin
              state_q <= ST_LOAD;
            end else if (in_i.data.opcode == OP_UPDATE) begin
              state_q <= ST_MUL1;
            end else begin
              state_q <= ST_VIEW;
            end
          end
        end
        ST_LOAD: begin
          if (item_q.last_of_batch) begin
            active_q <= lim;
          end
          state_q <= ST_VIEW;
        end
        ST_MUL1: begin
          state_q <= ST_ACC1;
        end
        ST_ACC1: begin
          q1_q    <= mac_res;
          state_q <= ST_MUL2;
        end
        ST_MUL2: begin
          state_q <= ST_ACC2;
        end
        ST_ACC2: begin
          if (item_q.last_of_batch && lim > active_q) begin
            active_q <= lim;
          end
          state_q <= ST_VIEW;
        end
        ST_VIEW: begin
          if (ch_ext < active_q) begin
            view_phase_q <= rd_phase;
            view_eff_q   <= eff_lvl;
            view_base_q  <= rd_base;
            view_accum_q <= rd_accum;
          end else begin
            view_phase_q <= PH_FAULT;
            view_eff_q   <= '0;
            view_base_q  <= '0;
            view_accum_q <= '0;
          end
          idx_q   <= '0;
          sum_q   <= '0;
          iso_q   <= (active_q != '0);
          mask_q  <= '0;
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (idx_q < active_q) begin
            sum_q <= sum_q + SUM_W'(rd_accum);
            if (rd_phase == PH_CHARGE || rd_phase == PH_FAULT) begin
              iso_q <= 1'b0;
            end
            if (rd_phase == PH_FAULT) begin
              mask_q[idx_q[CH_W-1:0]] <= 1'b1;
            end
            idx_q <= idx_q + CNT_W'(1);
          end else if (active_q == '0) begin
            mean_q  <= '0;
            state_q <= ST_FINISH;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            mean_q  <= div_quot;
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid_q || out_o.ready) begin
            out_q.channel_out     <= item_q.channel;
            out_q.phase_code      <= view_phase_q;
            out_q.effective_level <= view_eff_q;
            out_q.baseline_out    <= view_base_q;
            out_q.accum_out       <= view_accum_q;
            out_q.isolation_ok    <= iso_q;
            out_q.fault_mask      <= mask_q;
            out_q.mean_accum      <= mean_q;
            out_valid_q           <= 1'b1;
            state_q               <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/dldt_mac.sv
module dldt_mac (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [dldt_pkg::DATA_W:0]  a_i,
  input  logic [dldt_pkg::RATE_W:0]         b_i,
  input  logic signed [dldt_pkg::DATA_W-1:0] addend_i,
  output logic signed [dldt_pkg::DATA_W-1:0] res_o
);
  import dldt_pkg::*;

  localparam int PROD_W = DATA_W + RATE_W + 3;
  localparam int RND_W  = PROD_W - RATE_W;
  localparam int MAX24  = 8388607;
  localparam int MIN24  = -8388608;

  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] biased;
  logic signed [RND_W:0]    sum;

  // signed operand times unsigned rate
  assign prod_d = PROD_W'(a_i) * PROD_W'($signed({1'b0, b_i}));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  // round to nearest (ties up) by 2^16, add, saturate to 24 bits
  always_comb begin
    biased = prod_q + PROD_W'(32768);
    sum    = (RND_W+1)'($signed(biased[PROD_W-1:RATE_W])) + (RND_W+1)'(addend_i);
    if (sum > (RND_W+1)'(MAX24)) begin
      res_o = DATA_W'(MAX24);
    end else if (sum < (RND_W+1)'(MIN24)) begin
      res_o = DATA_W'(MIN24);
    end else begin
      res_o = sum[DATA_W-1:0];
    end
  end

endmodule

>>> design/dldt_div.sv
module dldt_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [dldt_pkg::SUM_W-1:0] dividend_i,
  input  logic [dldt_pkg::CNT_W-1:0]        divisor_i,
  output logic                              done_o,
  output logic signed [dldt_pkg::DATA_W-1:0] quot_o
);
  import dldt_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy_q;
  logic              done_q;
  logic              neg_q;
  logic [STEP_W-1:0] step_q;
  logic [SUM_W-1:0]  num_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  den_q;
  logic [CNT_W:0]    trial;
  logic              fits;

  // one restoring step per cycle on the magnitude
  assign trial = {rem_q, num_q[SUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(SUM_W - 1);
      end else if (busy_q) begin
        step_q <= step_q - STEP_W'(1);
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[SUM_W-1];
      num_q <= dividend_i[SUM_W-1] ? SUM_W'(0) - SUM_W'(dividend_i) : SUM_W'(dividend_i);
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= {num_q[SUM_W-2:0], fits};
      rem_q <= fits ? CNT_W'(trial - {1'b0, den_q}) : trial[CNT_W-1:0];
    end
  end

  // truncation toward zero: sign applied to the magnitude quotient
  assign done_o = done_q;
  assign quot_o = neg_q ? DATA_W'(0) - num_q[DATA_W-1:0] : num_q[DATA_W-1:0];

endmodule

>>> tb/dark_level_drift_tracker_top_tb.sv
module dark_level_drift_tracker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dldt_pkg::*;

  localparam int CHANNELS = 8;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam longint MAX24 = 8388607;
  localparam longint MIN24 = -8388608;
  localparam logic [DATA_W-1:0] LVL_MAX = 24'h7FFFFF;
  localparam logic [DATA_W-1:0] LVL_MIN = 24'h800000;
  localparam int RANDOM_ITEMS = 1200;
  localparam int CYCLE_LIMIT  = 1200000;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_SHOWN    = 10;

  logic clk_i;
  logic rst_ni;

  dldt_in_if  in_bus ();
  dldt_out_if out_bus ();
  dldt_cfg_if cfg_bus ();

  dark_level_drift_tracker_top #(
    .CHANNELS(CHANNELS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus),
    .cfg_i (cfg_bus)
  );

  // tracker state as the testbench sees it
  logic signed [DATA_W-1:0] base_q [CHANNELS];
  logic signed [DATA_W-1:0] acc_q  [CHANNELS];
  logic signed [DATA_W-1:0] prev_q [CHANNELS];
  phase_e                   phase_q[CHANNELS];
  int unsigned              act_cnt;
  logic [RATE_W-1:0]        eta_q;
  logic [RATE_W-1:0]        leak_q;
  logic [LIM_W-1:0]         fault_lim_q;
  logic [LIM_W-1:0]         charge_lim_q;
  logic [LIM_W-1:0]         hold_lim_q;

  out_rsp_t pending_views[$];

  int  req_cnt;
  int  rsp_cnt;
  int  cfg_cnt;
  int  fail_cnt;
  int  shown_cnt;
  int  phase_hits[4];
  int  cycles;
  bit  no_idle;
  int  hold_len;
  bit  sink_hold;
  int  stall_left;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // cycle limit
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("[dark_level_drift_tracker_top] ERROR");
    $finish;
  end

  function automatic longint sat24(longint v);
    if (v > MAX24) return MAX24;
    if (v < MIN24) return MIN24;
    return v;
  endfunction

  // divide by 2^16, nearest, ties up
  function automatic longint round_q16(longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic logic [DATA_W-1:0] clamp24(longint v);
    longint s;
    s = sat24(v);
    return s[DATA_W-1:0];
  endfunction

  function automatic void reset_tracker();
    eta_q        = ETA_RST;
    leak_q       = LEAK_RST;
    fault_lim_q  = FAULT_RST;
    charge_lim_q = CHARGE_RST;
    hold_lim_q   = HOLD_RST;
    for (int i = 0; i < CHANNELS; i++) begin
      base_q[i]  = '0;
      acc_q[i]   = '0;
      prev_q[i]  = '0;
      phase_q[i] = PH_HOLD;
    end
    act_cnt = 0;
  endfunction

  // apply one request to the tracker state and build the channel view
  function automatic out_rsp_t next_view(in_req_t r);
    out_rsp_t    rsp;
    int unsigned ch;
    int unsigned lim;
    longint      smp, resid, dq, q, absq, absr, acc_total, mean, eff;
    logic [MASK_W-1:0] mask;
    logic        iso;
    ch  = r.channel;
    lim = (ch + 1 > CHANNELS) ? CHANNELS : ch + 1;
    smp = longint'($signed(r.sample_value));
    rsp = '0;

    if (r.opcode == OP_LOAD) begin
      if (ch < CHANNELS) begin
        base_q[ch]  = r.sample_value;
        acc_q[ch]   = '0;
        prev_q[ch]  = r.sample_value;
        phase_q[ch] = PH_HOLD;
      end
      if (r.last_of_batch) act_cnt = lim;
    end else if (r.opcode == OP_UPDATE) begin
      if (ch < CHANNELS) begin
        resid = smp - longint'(base_q[ch]);
        dq    = smp - longint'(prev_q[ch]);
        q     = longint'(acc_q[ch]);
        // gain step then leak step
        q = sat24(q + round_q16(longint'(eta_q) * resid));
        q = sat24(round_q16(q * (65536 - longint'(leak_q))));
        acc_q[ch] = q[DATA_W-1:0];
        absq = (q < 0) ? -q : q;
        absr = (resid < 0) ? -resid : resid;
        // classify, first match wins
        if (absq >= longint'(fault_lim_q) || absr >= longint'(fault_lim_q))
          phase_q[ch] = PH_FAULT;
        else if (resid > longint'(charge_lim_q) && dq > 0)
          phase_q[ch] = PH_CHARGE;
        else if (absq > longint'(hold_lim_q))
          phase_q[ch] = PH_RELAX;
        else
          phase_q[ch] = PH_HOLD;
        phase_hits[phase_q[ch]]++;
        prev_q[ch] = r.sample_value;
      end
      if (r.last_of_batch && lim > act_cnt) act_cnt = lim;
    end

    // status over the active channels
    iso       = (act_cnt > 0);
    mask      = '0;
    acc_total = 0;
    mean      = 0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (i < act_cnt) begin
        if (phase_q[i] == PH_CHARGE || phase_q[i] == PH_FAULT) iso = 1'b0;
        if (phase_q[i] == PH_FAULT) mask[i] = 1'b1;
        acc_total += longint'(acc_q[i]);
      end
    end
    if (act_cnt > 0) mean = acc_total / longint'(act_cnt);

    rsp.channel_out = r.channel;
    if (ch < act_cnt && ch < CHANNELS) begin
      eff = longint'(base_q[ch]) + longint'(acc_q[ch]);
      if (eff < 0) eff = 0;
      if (eff > MAX24) eff = MAX24;
      rsp.phase_code      = phase_q[ch];
      rsp.effective_level = eff[LIM_W-1:0];
      rsp.baseline_out    = base_q[ch];
      rsp.accum_out       = acc_q[ch];
    end else begin
      rsp.phase_code = PH_FAULT;
    end
    rsp.isolation_ok = iso;
    rsp.fault_mask   = mask;
    rsp.mean_accum   = mean[DATA_W-1:0];
    return rsp;
  endfunction

  function automatic void report(string what);
    fail_cnt++;
    if (shown_cnt < MAX_SHOWN) begin
      shown_cnt++;
      $display("mismatch: %s", what);
    end
  endfunction

  function automatic void cmp_field(string name, logic [CH_W-1:0] ch, logic [31:0] want,
                                    logic [31:0] got);
    if (want !== got)
      report($sformatf("response %0d ch %0d %s expected 0x%0h got 0x%0h",
                       rsp_cnt, ch, name, want, got));
  endfunction

  function automatic void check_view(out_rsp_t got);
    out_rsp_t want;
    if (pending_views.size() == 0) begin
      report($sformatf("response on ch %0d with no request waiting", got.channel_out));
      return;
    end
    want = pending_views.pop_front();
    cmp_field("channel_out", want.channel_out, want.channel_out, got.channel_out);
    cmp_field("phase_code", want.channel_out, want.phase_code, got.phase_code);
    cmp_field("effective_level", want.channel_out, want.effective_level, got.effective_level);
    cmp_field("baseline_out", want.channel_out, want.baseline_out, got.baseline_out);
    cmp_field("accum_out", want.channel_out, want.accum_out, got.accum_out);
    cmp_field("isolation_ok", want.channel_out, want.isolation_ok, got.isolation_ok);
    cmp_field("fault_mask", want.channel_out, want.fault_mask, got.fault_mask);
    cmp_field("mean_accum", want.channel_out, want.mean_accum, got.mean_accum);
    rsp_cnt++;
  endfunction

  // response monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) check_view(out_bus.data);
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  // long receiver hold-off, counted here
  always @(posedge clk_i) begin
    if (hold_len > 0) begin
      sink_hold = 1'b1;
      hold_len--;
    end else begin
      sink_hold = 1'b0;
    end
  end

  // response ready with random stalls
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold) begin
        out_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 99) < 20) stall_left = pick_gap();
      end
    end
  end

  // offer one request, wait for it to be taken, then record its view
  task automatic send_req(logic [1:0] op, int unsigned ch, logic [DATA_W-1:0] smp, bit last);
    in_req_t req;
    int      gap;
    req.opcode        = op;
    req.channel       = ch[CH_W-1:0];
    req.sample_value  = smp;
    req.last_of_batch = last;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.data  <= req;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    pending_views.push_back(next_view(req));
    req_cnt++;
  endtask

  // stop offering and wait for every response
  task automatic pause_until_idle();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_VAL_W-1:0] val);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= cfg_req_t'{index: idx, value: val};
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    case (idx)
      REG_ETA:    eta_q        = val[RATE_W-1:0];
      REG_LEAK:   leak_q       = val[RATE_W-1:0];
      REG_FAULT:  fault_lim_q  = val[LIM_W-1:0];
      REG_CHARGE: charge_lim_q = val[LIM_W-1:0];
      REG_HOLD:   hold_lim_q   = val[LIM_W-1:0];
      default: ;
    endcase
    cfg_cnt++;
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  // stimulus helpers
  function automatic logic [DATA_W-1:0] pick_baseline();
    case ($urandom_range(0, 9))
      0:       return LVL_MAX;
      1:       return LVL_MIN;
      2, 3, 4: return DATA_W'($urandom());
      default: return clamp24(longint'($urandom_range(0, 2097152)) - 1048576);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_dark(logic signed [DATA_W-1:0] lvl,
                                                  longint offset);
    longint noise;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: noise = longint'($urandom_range(0, 1200)) - 600;
      4, 5, 6:    noise = longint'($urandom_range(0, 16000)) - 8000;
      7, 8:       noise = longint'($urandom_range(0, 120000)) - 60000;
      default:    return DATA_W'($urandom());
    endcase
    return clamp24(longint'(lvl) + offset + noise);
  endfunction

  // occasionally misplace the batch end
  function automatic bit flip_last(bit last);
    return ($urandom_range(0, 24) == 0) ? !last : last;
  endfunction

  function automatic logic [CFG_VAL_W-1:0] pick_rate(bit for_leak);
    logic [CFG_VAL_W-1:0] v;
    v = CFG_VAL_W'($urandom());
    case ($urandom_range(0, 7))
      0:       v[RATE_W-1:0] = '0;
      1:       v[RATE_W-1:0] = '1;
      2, 3:    v[RATE_W-1:0] = for_leak ? RATE_W'($urandom_range(0, 300))
                                        : RATE_W'($urandom_range(300, 4000));
      4, 5:    v[RATE_W-1:0] = for_leak ? RATE_W'($urandom_range(300, 8000))
                                        : RATE_W'($urandom_range(4000, 40000));
      default: v[RATE_W-1:0] = RATE_W'($urandom());
    endcase
    return v;
  endfunction

  function automatic logic [CFG_VAL_W-1:0] pick_limit();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return CFG_VAL_W'($urandom_range(0, 3000));
      4, 5, 6: return CFG_VAL_W'($urandom_range(0, 40000));
      default: return CFG_VAL_W'($urandom());
    endcase
  endfunction

  task automatic maybe_read();
    if ($urandom_range(0, 9) == 0)
      send_req($urandom_range(0, 1) ? OP_READ : OP_SPARE, $urandom_range(0, CHANNELS - 1),
               DATA_W'($urandom()), 1'($urandom_range(0, 1)));
  endtask

  // load batch or reuse the active channels, then update batches with a ramp plus noise
  task automatic run_batch_sequence();
    logic signed [DATA_W-1:0] lvl [CHANNELS];
    int unsigned n;
    int          batches;
    int          ramp;
    if (act_cnt == 0 || $urandom_range(0, 3) != 0) begin
      n = $urandom_range(1, CHANNELS);
      for (int c = 0; c < n; c++) begin
        lvl[c] = pick_baseline();
        send_req(OP_LOAD, c, lvl[c], flip_last(c == n - 1));
        maybe_read();
      end
    end else begin
      n = act_cnt;
      for (int c = 0; c < CHANNELS; c++) lvl[c] = base_q[c];
    end
    batches = $urandom_range(1, 6);
    ramp    = int'($urandom_range(0, 800)) - 400;
    for (int k = 1; k <= batches; k++) begin
      for (int c = 0; c < n; c++) begin
        send_req(OP_UPDATE, c, pick_dark(lvl[c], longint'(ramp) * k), flip_last(c == n - 1));
        maybe_read();
      end
    end
  endtask

  task automatic run_noise();
    repeat ($urandom_range(1, 10))
      send_req(2'($urandom_range(0, 3)), $urandom_range(0, CHANNELS - 1),
               DATA_W'($urandom()), 1'($urandom_range(0, 1)));
  endtask

  task automatic apply_random_settings();
    pause_until_idle();
    write_reg(REG_ETA, pick_rate(1'b0));
    write_reg(REG_LEAK, pick_rate(1'b1));
    write_reg(REG_FAULT, pick_limit());
    write_reg(REG_CHARGE, pick_limit());
    write_reg(REG_HOLD, pick_limit());
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_IDX_W'(REG_HOLD + 1 + $urandom_range(0, 2)), CFG_VAL_W'($urandom()));
  endtask

  // views before any channel is active
  task automatic test_reset_view();
    send_req(OP_READ, 0, LVL_MAX, 1'b1);
    send_req(OP_SPARE, 7, LVL_MIN, 1'b0);
    send_req(OP_UPDATE, 3, 5000, 1'b0);
  endtask

  // field extremes and each classification at reset settings
  task automatic test_directed_edges();
    send_req(OP_LOAD, 0, LVL_MAX, 1'b0);
    send_req(OP_LOAD, 1, LVL_MIN, 1'b0);
    send_req(OP_LOAD, 7, 0, 1'b1);
    // channel never loaded since reset
    send_req(OP_READ, 3, 0, 1'b0);
    // residuals of full width both ways, level clamps at zero
    send_req(OP_UPDATE, 0, LVL_MIN, 1'b0);
    send_req(OP_UPDATE, 1, LVL_MAX, 1'b0);
    // rising past the charge threshold, then flat
    send_req(OP_UPDATE, 2, 2000, 1'b0);
    send_req(OP_UPDATE, 2, 2000, 1'b0);
    send_req(OP_UPDATE, 3, -2000, 1'b0);
    // residual exactly at the fault limit and one below
    send_req(OP_UPDATE, 4, DATA_W'(FAULT_RST), 1'b0);
    send_req(OP_UPDATE, 5, DATA_W'(FAULT_RST - 1), 1'b0);
    // load batch end lowers the count
    send_req(OP_LOAD, 2, 300, 1'b1);
    send_req(OP_READ, 5, 0, 1'b1);
    // inactive channel still updates, then count rises
    send_req(OP_UPDATE, 6, 4000, 1'b0);
    send_req(OP_UPDATE, 6, 4000, 1'b1);
    send_req(OP_SPARE, 6, LVL_MAX, 1'b1);
    send_req(OP_READ, 7, 0, 1'b0);
    // update batch end never lowers the count
    send_req(OP_UPDATE, 1, 0, 1'b1);
    send_req(OP_UPDATE, 7, 1, 1'b1);
  endtask

  // register extremes, saturation of accumulator and level
  task automatic test_register_extremes();
    pause_until_idle();
    write_reg(REG_ETA, '1);
    write_reg(REG_LEAK, '0);
    write_reg(REG_FAULT, '1);
    write_reg(REG_CHARGE, '0);
    write_reg(REG_HOLD, '0);
    for (int idx = REG_HOLD + 1; idx < 2 ** CFG_IDX_W; idx++)
      write_reg(CFG_IDX_W'(idx), CFG_VAL_W'($urandom()));
    send_req(OP_LOAD, 0, 8380000, 1'b0);
    send_req(OP_LOAD, 1, -8380000, 1'b0);
    send_req(OP_LOAD, 2, 0, 1'b0);
    send_req(OP_LOAD, 3, 1000, 1'b1);
    repeat (2) begin
      send_req(OP_UPDATE, 0, LVL_MAX, 1'b0);
      send_req(OP_UPDATE, 1, LVL_MIN, 1'b0);
      send_req(OP_UPDATE, 2, LVL_MAX, 1'b0);
      send_req(OP_UPDATE, 3, -1000, 1'b1);
    end
    // zero gain, full leak, everything faults
    pause_until_idle();
    write_reg(REG_ETA, '0);
    write_reg(REG_LEAK, '1);
    write_reg(REG_FAULT, '0);
    write_reg(REG_CHARGE, '1);
    write_reg(REG_HOLD, '1);
    for (int c = 0; c < 4; c++) send_req(OP_UPDATE, c, DATA_W'($urandom()), c == 3);
    // full gain with full leak, tiny accumulators
    pause_until_idle();
    write_reg(REG_ETA, '1);
    write_reg(REG_FAULT, '1);
    write_reg(REG_HOLD, '0);
    for (int c = 0; c < 4; c++) send_req(OP_UPDATE, c, DATA_W'($urandom()), c == 3);
  endtask

  // receiver holds off while requests keep coming, then sender waits for all
  task automatic test_backpressure();
    pause_until_idle();
    no_idle  = 1'b1;
    hold_len = 400;
    for (int c = 0; c < 4; c++) send_req(OP_LOAD, c, pick_baseline(), c == 3);
    for (int k = 0; k < 5; k++)
      for (int c = 0; c < 4; c++) send_req(OP_UPDATE, c, pick_dark(base_q[c], 0), c == 3);
    no_idle = 1'b0;
    pause_until_idle();
  endtask

  // mostly well-formed batches, some noise, periodic new settings
  task automatic test_random_traffic();
    int stop_at;
    int next_cfg;
    stop_at  = req_cnt + RANDOM_ITEMS;
    next_cfg = req_cnt;
    while (req_cnt < stop_at) begin
      if (req_cnt >= next_cfg) begin
        apply_random_settings();
        next_cfg = req_cnt + $urandom_range(100, 250);
      end
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 8) run_batch_sequence();
      else run_noise();
    end
    no_idle = 1'b0;
  endtask

  // main sequence
  initial begin
    rst_ni        <= 1'b0;
    in_bus.valid  <= 1'b0;
    in_bus.data   <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.data  <= '0;
    req_cnt    = 0;
    rsp_cnt    = 0;
    cfg_cnt    = 0;
    fail_cnt   = 0;
    shown_cnt  = 0;
    phase_hits = '{default: 0};
    no_idle    = 1'b0;
    hold_len   = 0;
    sink_hold  = 1'b0;
    stall_left = 0;
    reset_tracker();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_view();
    test_directed_edges();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();

    pause_until_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_views.size() != 0)
      report($sformatf("%0d responses never arrived", pending_views.size()));

    $display("covered %0d requests, %0d responses checked, %0d register writes",
             req_cnt, rsp_cnt, cfg_cnt);
    $display("update outcomes hold/charge/relax/fault %0d/%0d/%0d/%0d, %0d failures",
             phase_hits[PH_HOLD], phase_hits[PH_CHARGE], phase_hits[PH_RELAX],
             phase_hits[PH_FAULT], fail_cnt);
    if (fail_cnt == 0) begin
      $display("[dark_level_drift_tracker_top] OK");
    end else begin
      $display("[dark_level_drift_tracker_top] ERROR");
    end
    $finish;
  end

endmodule

>>> dark_level_drift_tracker_top.f
design/dldt_pkg.sv
design/dldt_if.sv
design/dldt_mac.sv
design/dldt_div.sv
design/dark_level_drift_tracker_top.sv
tb/dark_level_drift_tracker_top_tb.sv
